// File: rtl/krl_pkg.sv
// ----------------------------------------------------------------------------
// krl_pkg
// Shared types and constants for the keyed attempt rate limiter.
// ----------------------------------------------------------------------------
package krl_pkg;

  localparam int KEY_W   = 64;
  localparam int COUNT_W = 16;
  localparam int TIME_W  = 32;
  localparam int ACT_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // action codes
  localparam logic [ACT_W-1:0] ACT_CHECK = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FAIL  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd2;

  localparam logic               RST_LIMIT_ENABLE  = 1'b0;
  localparam logic [COUNT_W-1:0] RST_MAX_ATTEMPTS  = 16'd5;
  localparam logic [TIME_W-1:0]  RST_WINDOW_LENGTH = 32'd300;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  start;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_MISS,
    ST_EVICT,
    ST_NONE
  } state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_HIT,
    WR_NEW,
    WR_EVICT
  } wr_sel_t;

  typedef struct packed {
    logic    load;      // latch the input word
    logic    idx_clr;   // restart the table scan at entry 0
    logic    rd_issue;  // read the entry at the scan index, advance
    wr_sel_t wr_sel;
    logic    res_load;  // load the result register
    logic    res_hit;   // result comes from a matching entry
  } cmd_t;

  typedef struct packed {
    logic bypass;   // input word needs no table access
    logic is_fail;
    logic full;
    logic idx_end;  // scan index reached the fill count
    logic dv;       // read data valid this cycle
    logic match;
  } sts_t;

endpackage

// File: rtl/keyed_attempt_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// keyed_attempt_rate_limiter_core
// Keyed fixed-window limiter of failed login attempts over an entry table.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per request: action (check, record failure, clear),
//           64-bit user key digest and the current time in seconds.
//   out_* : one word per request: blocked and found.
//   cfg_* : register writes (enable, max attempts, window length); cfg_ready
//           is always high. Write registers only while the block is idle.
// Sequencing:
//   A request with table work scans entries one per cycle through the
//   table RAM read port. A hit writes the updated entry and loads the
//   result; a miss loads the result and, for a failure with room, adds a new entry.
//   A failure for an unknown key on a full table adds a second scan for the
//   oldest window start, then replaces that entry. Requests needing no
//   table work pass through a single state that loads the result. One
//   request is in flight at a time.
// Reset:
//   Synchronous, active low. The table is empty and registers take their
//   defaults; no clearing pass is needed.
// Stall:
//   The result waits in an output register and in_ready stays low until it
//   is taken; a new request can be accepted in the cycle the result is taken.
// ----------------------------------------------------------------------------
module keyed_attempt_rate_limiter_core #(
  parameter int ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [krl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [krl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [krl_pkg::ACT_W-1:0]       in_action,
  input  logic [krl_pkg::KEY_W-1:0]       in_user_key,
  input  logic [krl_pkg::TIME_W-1:0]      in_now_seconds,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_blocked,
  output logic                            out_found
);

  krl_pkg::cmd_t cmd;
  krl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  krl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  krl_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_action     (in_action),
    .in_user_key   (in_user_key),
    .in_now_seconds(in_now_seconds),
    .cmd           (cmd),
    .sts           (sts),
    .out_blocked   (out_blocked),
    .out_found     (out_found)
  );

endmodule

// File: rtl/krl_ram.sv
// ----------------------------------------------------------------------------
// krl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module krl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the last read word while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/krl_dp.sv
// ----------------------------------------------------------------------------
// krl_dp
// Datapath: config registers, entry table, scan index, eviction tracker,
// hit update and result register.
// ----------------------------------------------------------------------------
module krl_dp #(
  parameter int ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [krl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [krl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [krl_pkg::ACT_W-1:0]       in_action,
  input  logic [krl_pkg::KEY_W-1:0]       in_user_key,
  input  logic [krl_pkg::TIME_W-1:0]      in_now_seconds,
  input  krl_pkg::cmd_t                   cmd,
  output krl_pkg::sts_t                   sts,
  output logic                            out_blocked,
  output logic                            out_found
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = IW + 1;

  // config
  logic                         enable_r;
  logic [krl_pkg::COUNT_W-1:0]  max_r;
  logic [krl_pkg::TIME_W-1:0]   wlen_r;

  // latched input word
  logic [krl_pkg::ACT_W-1:0]    act_r;
  logic [krl_pkg::KEY_W-1:0]    key_r;
  logic [krl_pkg::TIME_W-1:0]   now_r;

  logic [CW-1:0]                used_r;
  logic [CW-1:0]                idx_r;
  logic                         dv_r;
  logic [IW-1:0]                dix_r;
  logic [IW-1:0]                target_r;
  logic [krl_pkg::TIME_W-1:0]   oldest_r;
  logic                         blocked_r;
  logic                         found_r;

  krl_pkg::entry_t              rdata;
  krl_pkg::entry_t              hit_entry;
  krl_pkg::entry_t              new_entry;
  krl_pkg::entry_t              wdata;
  logic [IW-1:0]                waddr;
  logic                         wr_en;
  logic [krl_pkg::TIME_W-1:0]   age;
  logic                         expired;
  logic                         hit_blocked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= krl_pkg::RST_LIMIT_ENABLE;
      max_r    <= krl_pkg::RST_MAX_ATTEMPTS;
      wlen_r   <= krl_pkg::RST_WINDOW_LENGTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        krl_pkg::CFG_LIMIT_ENABLE:  enable_r <= cfg_data[0];
        krl_pkg::CFG_MAX_ATTEMPTS:  max_r    <= cfg_data[krl_pkg::COUNT_W-1:0];
        krl_pkg::CFG_WINDOW_LENGTH: wlen_r   <= cfg_data[krl_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      key_r <= in_user_key;
      now_r <= in_now_seconds;
    end
  end

  // scan index and read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      dv_r   <= 1'b0;
      used_r <= '0;
    end else begin
      dv_r <= cmd.rd_issue;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.rd_issue) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.wr_sel == krl_pkg::WR_NEW) begin
        used_r <= used_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      dix_r <= idx_r[IW-1:0];
    end
  end

  // oldest window start; entry 0 seeds the search, ties keep the lower index
  always_ff @(posedge clk) begin
    if (dv_r && (dix_r == '0 || rdata.start < oldest_r)) begin
      oldest_r <= rdata.start;
      target_r <= dix_r;
    end
  end

  always_comb begin
    age         = now_r - rdata.start;
    expired     = age > wlen_r;
    hit_blocked = !expired && (rdata.count >= max_r);

    hit_entry = rdata;
    case (act_r)
      krl_pkg::ACT_CHECK: begin
        if (expired) begin
          hit_entry.count = '0;
          hit_entry.start = now_r;
        end
      end
      krl_pkg::ACT_FAIL: begin
        if (expired) begin
          hit_entry.count = krl_pkg::COUNT_W'(1);
          hit_entry.start = now_r;
        end else if (rdata.count != krl_pkg::COUNT_MAX) begin
          hit_entry.count = rdata.count + krl_pkg::COUNT_W'(1);
        end
      end
      krl_pkg::ACT_CLEAR: begin
        hit_entry.count = '0;
        hit_entry.start = '0;
      end
      default: ;
    endcase

    new_entry.key   = key_r;
    new_entry.count = krl_pkg::COUNT_W'(1);
    new_entry.start = now_r;

    wr_en = 1'b1;
    case (cmd.wr_sel)
      krl_pkg::WR_HIT: begin
        waddr = dix_r;
        wdata = hit_entry;
      end
      krl_pkg::WR_NEW: begin
        waddr = used_r[IW-1:0];
        wdata = new_entry;
      end
      krl_pkg::WR_EVICT: begin
        waddr = target_r;
        wdata = new_entry;
      end
      default: begin
        wr_en = 1'b0;
        waddr = dix_r;
        wdata = new_entry;
      end
    endcase
  end

  krl_ram #(
    .WIDTH(krl_pkg::ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(waddr),
    .wr_data(wdata),
    .rd_en  (cmd.rd_issue),
    .rd_addr(idx_r[IW-1:0]),
    .rd_data(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      blocked_r <= cmd.res_hit && hit_blocked && (act_r == krl_pkg::ACT_CHECK);
      found_r   <= cmd.res_hit;
    end
  end

  always_comb begin
    sts.bypass  = !((((in_action == krl_pkg::ACT_CHECK) || (in_action == krl_pkg::ACT_FAIL))
                     && enable_r)
                    || ((in_action == krl_pkg::ACT_CLEAR) && (in_user_key != '0)));
    sts.is_fail = act_r == krl_pkg::ACT_FAIL;
    sts.full    = used_r == CW'(ENTRIES);
    sts.idx_end = idx_r == used_r;
    sts.dv      = dv_r;
    sts.match   = dv_r && (rdata.key == key_r);
  end

  assign out_blocked = blocked_r;
  assign out_found   = found_r;

endmodule

// File: rtl/krl_ctrl.sv
// ----------------------------------------------------------------------------
// krl_ctrl
// Controller: sequences lookup scan, update, insert or eviction scan, and
// owns the result handshake.
// ----------------------------------------------------------------------------
module krl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  krl_pkg::sts_t   sts,
  output krl_pkg::cmd_t   cmd
);

  krl_pkg::state_t state_r;
  krl_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            accept;

  assign in_ready = (state_r == krl_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      krl_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = sts.bypass ? krl_pkg::ST_NONE : krl_pkg::ST_SCAN;
        end
      end
      krl_pkg::ST_SCAN: begin
        if (sts.match) begin
          state_nxt = krl_pkg::ST_HIT;
        end else if (sts.idx_end && !sts.dv) begin
          state_nxt = krl_pkg::ST_MISS;
        end
      end
      krl_pkg::ST_HIT:  state_nxt = krl_pkg::ST_IDLE;
      krl_pkg::ST_MISS: begin
        state_nxt = (sts.is_fail && sts.full) ? krl_pkg::ST_EVICT : krl_pkg::ST_IDLE;
      end
      krl_pkg::ST_EVICT: begin
        if (sts.idx_end && !sts.dv) begin
          state_nxt = krl_pkg::ST_IDLE;
        end
      end
      krl_pkg::ST_NONE: state_nxt = krl_pkg::ST_IDLE;
      default:          state_nxt = krl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.wr_sel   = krl_pkg::WR_NONE;
    case (state_r)
      krl_pkg::ST_IDLE: begin
        cmd.load    = accept;
        cmd.idx_clr = accept;
      end
      krl_pkg::ST_SCAN: begin
        cmd.rd_issue = !sts.idx_end && !sts.match;
      end
      krl_pkg::ST_HIT: begin
        cmd.wr_sel   = krl_pkg::WR_HIT;
        cmd.res_load = 1'b1;
        cmd.res_hit  = 1'b1;
      end
      krl_pkg::ST_MISS: begin
        if (sts.is_fail && sts.full) begin
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.res_load = 1'b1;
          if (sts.is_fail) begin
            cmd.wr_sel = krl_pkg::WR_NEW;
          end
        end
      end
      krl_pkg::ST_EVICT: begin
        cmd.rd_issue = !sts.idx_end;
        if (sts.idx_end && !sts.dv) begin
          cmd.wr_sel   = krl_pkg::WR_EVICT;
          cmd.res_load = 1'b1;
        end
      end
      krl_pkg::ST_NONE: begin
        cmd.res_load = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= krl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/krl_chk.sv
// ----------------------------------------------------------------------------
// krl_chk
// Port-level checks for the keyed attempt rate limiter.
// ----------------------------------------------------------------------------
module krl_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_blocked,
  input logic                            out_found
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_blocked) && $stable(out_found))
    else $error("result word changed while stalled");

  // blocking needs a matching entry
  a_blocked_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_blocked |-> out_found)
    else $error("blocked without a matching entry");

  // one request in flight: busy the cycle after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keyed_attempt_rate_limiter_core krl_chk u_krl_chk (.*);

// File: tb/krl_attempt_checker.sv
// ----------------------------------------------------------------------------
// krl_attempt_checker
// Watches the register, request and result channels of the attempt limiter,
// keeps its own copy of the entry table and registers, and compares every
// result word against the verdict predicted for the oldest open request.
// ----------------------------------------------------------------------------
module krl_attempt_checker #(
  parameter int ENTRIES = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [krl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [krl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [krl_pkg::ACT_W-1:0]      in_action,
  input  logic [krl_pkg::KEY_W-1:0]      in_user_key,
  input  logic [krl_pkg::TIME_W-1:0]     in_now_seconds,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_blocked,
  input  logic                           out_found,
  output int                             pending_results,
  output int                             fail_count
);

  typedef struct packed {
    logic blocked;
    logic found;
  } verdict_t;

  logic [krl_pkg::KEY_W-1:0]   tbl_key   [ENTRIES];
  logic [krl_pkg::COUNT_W-1:0] tbl_count [ENTRIES];
  logic [krl_pkg::TIME_W-1:0]  tbl_start [ENTRIES];
  int                          tbl_used;

  logic                        lim_en;
  logic [krl_pkg::COUNT_W-1:0] lim_max;
  logic [krl_pkg::TIME_W-1:0]  lim_window;

  verdict_t verdict_q [$];

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int find_entry(input logic [krl_pkg::KEY_W-1:0] key);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic bit window_over(input int slot, input logic [krl_pkg::TIME_W-1:0] now);
    logic [krl_pkg::TIME_W-1:0] age;
    age = now - tbl_start[slot];
    return age > lim_window;
  endfunction

  // Apply one request to the shadow table and return its verdict.
  function automatic verdict_t predict_verdict(input logic [krl_pkg::ACT_W-1:0]  act,
                                               input logic [krl_pkg::KEY_W-1:0]  key,
                                               input logic [krl_pkg::TIME_W-1:0] now);
    verdict_t                   v;
    int                         slot;
    int                         victim;
    logic [krl_pkg::TIME_W-1:0] oldest;
    v = '0;
    case (act)
      krl_pkg::ACT_CHECK: begin
        if (lim_en) begin
          slot = find_entry(key);
          if (slot >= 0) begin
            v.found = 1'b1;
            if (window_over(slot, now)) begin
              tbl_count[slot] = '0;
              tbl_start[slot] = now;
            end else if (tbl_count[slot] >= lim_max) begin
              v.blocked = 1'b1;
            end
          end
        end
      end
      krl_pkg::ACT_FAIL: begin
        if (lim_en) begin
          slot = find_entry(key);
          if (slot >= 0) begin
            v.found = 1'b1;
            if (window_over(slot, now)) begin
              tbl_count[slot] = krl_pkg::COUNT_W'(1);
              tbl_start[slot] = now;
            end else if (tbl_count[slot] != krl_pkg::COUNT_MAX) begin
              tbl_count[slot] = tbl_count[slot] + 1'b1;
            end
          end else begin
            if (tbl_used < ENTRIES) begin
              victim = tbl_used;
              tbl_used++;
            end else begin
              // replace the oldest window start, lowest index on a tie
              victim = 0;
              oldest = tbl_start[0];
              for (int i = 1; i < ENTRIES; i++) begin
                if (tbl_start[i] < oldest) begin
                  oldest = tbl_start[i];
                  victim = i;
                end
              end
            end
            tbl_key[victim]   = key;
            tbl_count[victim] = krl_pkg::COUNT_W'(1);
            tbl_start[victim] = now;
          end
        end
      end
      krl_pkg::ACT_CLEAR: begin
        if (key != '0) begin
          slot = find_entry(key);
          if (slot >= 0) begin
            v.found = 1'b1;
            tbl_count[slot] = '0;
            tbl_start[slot] = '0;
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin : monitor
    verdict_t want;
    if (!rst_n) begin
      tbl_used   = 0;
      lim_en     = krl_pkg::RST_LIMIT_ENABLE;
      lim_max    = krl_pkg::RST_MAX_ATTEMPTS;
      lim_window = krl_pkg::RST_WINDOW_LENGTH;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          krl_pkg::CFG_LIMIT_ENABLE:  lim_en     = cfg_data[0];
          krl_pkg::CFG_MAX_ATTEMPTS:  lim_max    = cfg_data[krl_pkg::COUNT_W-1:0];
          krl_pkg::CFG_WINDOW_LENGTH: lim_window = cfg_data[krl_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
      // retire the result word before taking a new request on the same edge
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_error($sformatf("result word blocked=%b found=%b with none open",
                                 out_blocked, out_found));
        end else begin
          want = verdict_q.pop_front();
          if (out_blocked !== want.blocked) begin
            report_error($sformatf("blocked got %b, expected %b", out_blocked,
                                   want.blocked));
          end
          if (out_found !== want.found) begin
            report_error($sformatf("found got %b, expected %b", out_found, want.found));
          end
        end
      end
      if (in_valid && in_ready) begin
        verdict_q.push_back(predict_verdict(in_action, in_user_key, in_now_seconds));
      end
    end
    pending_results <= verdict_q.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keyed attempt rate limiter core.
// Directed requests cover disabled limiting, window edges, time wrap and
// empty keys; random requests then run under several register settings,
// fill the table and force evictions, with random idling on both channels,
// a long result stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ENTRIES      = 256;
  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 64;
  localparam int MAX_GAP      = 17;
  localparam int LONG_HOLD    = 400;
  localparam int POOL_N       = 16;

  localparam logic [krl_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [krl_pkg::KEY_W-1:0] KEY_EMPTY = '0;
  localparam logic [krl_pkg::KEY_W-1:0] KEY_ONES  = '1;
  localparam logic [krl_pkg::KEY_W-1:0] KEY_A     = 64'h0123_4567_89ab_cdef;
  localparam logic [krl_pkg::KEY_W-1:0] KEY_SAT   = 64'hfedc_ba98_7654_3210;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           cfg_valid      = 1'b0;
  logic                           cfg_ready;
  logic [krl_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [krl_pkg::CFG_DATA_W-1:0] cfg_data       = '0;
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  logic [krl_pkg::ACT_W-1:0]      in_action      = '0;
  logic [krl_pkg::KEY_W-1:0]      in_user_key    = '0;
  logic [krl_pkg::TIME_W-1:0]     in_now_seconds = '0;
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  logic                           out_blocked;
  logic                           out_found;

  int                         pending_results;
  int                         fail_count;
  bit                         no_gaps     = 1'b0;
  int                         hold_cycles = 0;
  logic [krl_pkg::TIME_W-1:0] clock_s     = '0;
  logic [krl_pkg::KEY_W-1:0]  key_pool [POOL_N];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keyed_attempt_rate_limiter_core #(
    .ENTRIES (ENTRIES)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_user_key    (in_user_key),
    .in_now_seconds (in_now_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_blocked    (out_blocked),
    .out_found      (out_found)
  );

  krl_attempt_checker #(
    .ENTRIES (ENTRIES)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_user_key     (in_user_key),
    .in_now_seconds  (in_now_seconds),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_blocked     (out_blocked),
    .out_found       (out_found),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  function automatic logic [krl_pkg::KEY_W-1:0] fresh_key();
    return {$urandom, $urandom};
  endfunction

  // Offer one request word; valid stays high on return so a back-to-back
  // word can follow in the same step. Callers lower it when they stop.
  task automatic send_item(input logic [krl_pkg::ACT_W-1:0]  act,
                           input logic [krl_pkg::KEY_W-1:0]  key,
                           input logic [krl_pkg::TIME_W-1:0] now);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_user_key    <= key;
    in_now_seconds <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and hold until every open request has its result.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    @(posedge clk);
  endtask

  task automatic cfg_word(input logic [krl_pkg::CFG_IDX_W-1:0]  idx,
                          input logic [krl_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_regs(input logic                        en,
                            input logic [krl_pkg::COUNT_W-1:0] max_att,
                            input logic [krl_pkg::TIME_W-1:0]  win);
    drain_results();
    cfg_word(krl_pkg::CFG_LIMIT_ENABLE, {{(krl_pkg::CFG_DATA_W-1){1'b0}}, en});
    cfg_word(krl_pkg::CFG_MAX_ATTEMPTS,
             {{(krl_pkg::CFG_DATA_W-krl_pkg::COUNT_W){1'b0}}, max_att});
    cfg_word(krl_pkg::CFG_WINDOW_LENGTH, win);
    cfg_valid <= 1'b0;
  endtask

  // Random requests, mostly on a small key pool so entries get hit again.
  task automatic random_phase(input int items, input int fresh_pct, input int hold_at,
                              input int pause_at);
    int                        pick;
    logic [krl_pkg::ACT_W-1:0] act;
    logic [krl_pkg::KEY_W-1:0] key;
    for (int n = 0; n < items; n++) begin
      if (n == hold_at) hold_cycles = LONG_HOLD;
      if (n == pause_at) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 40) act = krl_pkg::ACT_FAIL;
      else if (pick < 75) act = krl_pkg::ACT_CHECK;
      else if (pick < 93) act = krl_pkg::ACT_CLEAR;
      else act = ACT_UNUSED;
      if ($urandom_range(0, 99) < fresh_pct) key = fresh_key();
      else key = key_pool[$urandom_range(0, POOL_N - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 85) clock_s += $urandom_range(0, 12);
      else if (pick < 95) clock_s += $urandom_range(0, 400);
      else clock_s += $urandom;
      send_item(act, key, clock_s);
    end
  endtask

  initial begin : result_sink
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_cycles != 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    for (int k = 0; k < POOL_N; k++) key_pool[k] = fresh_key();
    key_pool[0] = KEY_EMPTY;
    key_pool[1] = KEY_ONES;
    key_pool[2] = KEY_A;
    key_pool[3] = KEY_SAT;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: limiting off, only clear touches the table
    send_item(krl_pkg::ACT_CHECK, KEY_A, 32'd10);
    send_item(krl_pkg::ACT_FAIL, KEY_A, 32'd10);
    send_item(krl_pkg::ACT_CLEAR, KEY_A, 32'd10);
    send_item(ACT_UNUSED, KEY_A, 32'd10);

    write_regs(1'b1, 16'd2, 32'd100);
    send_item(krl_pkg::ACT_CHECK, KEY_A, 32'd1000);
    send_item(krl_pkg::ACT_FAIL, KEY_A, 32'd1000);
    send_item(krl_pkg::ACT_FAIL, KEY_A, 32'd1010);
    send_item(krl_pkg::ACT_CHECK, KEY_A, 32'd1020);
    // age equal to the window keeps it open, one more second restarts it
    send_item(krl_pkg::ACT_CHECK, KEY_A, 32'd1100);
    send_item(krl_pkg::ACT_CHECK, KEY_A, 32'd1101);
    send_item(krl_pkg::ACT_FAIL, KEY_EMPTY, 32'd1102);
    send_item(krl_pkg::ACT_CHECK, KEY_EMPTY, 32'd1102);
    send_item(krl_pkg::ACT_CLEAR, KEY_EMPTY, 32'd1102);
    send_item(krl_pkg::ACT_CLEAR, KEY_A, 32'd1102);
    send_item(krl_pkg::ACT_CHECK, KEY_A, 32'd1103);
    // time wraps between these two failures
    send_item(krl_pkg::ACT_FAIL, KEY_ONES, 32'hffff_fff0);
    send_item(krl_pkg::ACT_FAIL, KEY_ONES, 32'h0000_0010);
    send_item(krl_pkg::ACT_CHECK, KEY_ONES, 32'h0000_0010);
    send_item(ACT_UNUSED, KEY_ONES, 32'hffff_ffff);

    write_regs(1'b1, 16'd0, 32'd0);
    send_item(krl_pkg::ACT_CHECK, KEY_A, 32'd1103);
    send_item(krl_pkg::ACT_FAIL, KEY_A, 32'd1104);
    send_item(krl_pkg::ACT_CLEAR, KEY_SAT, 32'd1104);
    clock_s = 32'd1300;

    write_regs(1'b1, 16'd3, 32'd50);
    random_phase(90, 3, -1, -1);
    write_regs(1'b0, 16'd7, 32'd1000);
    random_phase(60, 3, -1, -1);
    // back-to-back words against a long result stall
    write_regs(1'b1, 16'd1, 32'd20);
    no_gaps = 1'b1;
    random_phase(90, 3, 30, -1);
    no_gaps = 1'b0;
    write_regs(1'b1, 16'd0, 32'd0);
    random_phase(90, 3, -1, 45);
    write_regs(1'b1, krl_pkg::COUNT_MAX, '1);
    random_phase(90, 3, -1, -1);

    // fill the table with new keys; close starts give eviction ties
    write_regs(1'b1, 16'd4, 32'd200);
    repeat (ENTRIES + 4) begin
      clock_s += $urandom_range(0, 2);
      send_item(krl_pkg::ACT_FAIL, fresh_key(), clock_s);
    end

    write_regs(1'b1, 16'd2, 32'd60);
    random_phase(200, 25, 100, -1);
    write_regs(1'b1, 16'd3, 32'hffff_ffff);
    random_phase(250, 25, -1, 70);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/krl_pkg.sv
rtl/krl_ram.sv
rtl/krl_dp.sv
rtl/krl_ctrl.sv
rtl/keyed_attempt_rate_limiter_core.sv
rtl/krl_chk.sv
tb/krl_attempt_checker.sv
tb/tb_top.sv
